>>> rtl/pti_pkg.sv
`default_nettype none

package pti_pkg;

  localparam int MAX_DEGREE = 5;
  localparam int NUM_COEF   = MAX_DEGREE + 1;
  localparam int DEG_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_W      = 24;

  localparam logic [62:0] AREA_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] HORNER_CAP = 63'h4000_0000_0000_0000;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DEGREE = 3'd0;
  localparam cfg_idx_t REG_COEF_0 = 3'd1;
  localparam cfg_idx_t REG_COEF_5 = 3'd6;

  typedef logic [3:0] pc_t;

  localparam pc_t ST_LOAD     = 4'd0;
  localparam pc_t ST_CHECK    = 4'd1;
  localparam pc_t ST_DIV      = 4'd2;
  localparam pc_t ST_SETUP    = 4'd3;
  localparam pc_t ST_POINT    = 4'd4;
  localparam pc_t ST_HMUL_LO  = 4'd5;
  localparam pc_t ST_HMUL_HI  = 4'd6;
  localparam pc_t ST_HORNER   = 4'd7;
  localparam pc_t ST_AMUL_LO  = 4'd8;
  localparam pc_t ST_AMUL_HI  = 4'd9;
  localparam pc_t ST_SUM      = 4'd10;
  localparam pc_t ST_EMIT     = 4'd11;
  localparam pc_t ST_WRAP     = 4'd12;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_SETUP,
    OP_HINIT,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_HORNER,
    OP_SUM,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    CND_NEXT,
    CND_ALWAYS,
    CND_NO_INPUT,
    CND_BAD,
    CND_DIV_BUSY,
    CND_DEG_ZERO,
    CND_K_MORE,
    CND_PT_MORE,
    CND_OUT_BUSY
  } cnd_t;

  typedef struct packed {
    op_t  op;
    cnd_t cnd;
    logic use_h;
    pc_t  target;
  } ctrl_t;

  // jump to target when the condition holds, else advance one step
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    w = '{op: OP_NOP, cnd: CND_ALWAYS, use_h: 1'b0, target: ST_LOAD};
    unique case (pc)
      ST_LOAD:    w = '{op: OP_LOAD,   cnd: CND_NO_INPUT, use_h: 1'b0, target: ST_LOAD};
      ST_CHECK:   w = '{op: OP_NOP,    cnd: CND_BAD,      use_h: 1'b0, target: ST_EMIT};
      ST_DIV:     w = '{op: OP_DIV,    cnd: CND_DIV_BUSY, use_h: 1'b0, target: ST_DIV};
      ST_SETUP:   w = '{op: OP_SETUP,  cnd: CND_NEXT,     use_h: 1'b0, target: ST_LOAD};
      ST_POINT:   w = '{op: OP_HINIT,  cnd: CND_DEG_ZERO, use_h: 1'b0, target: ST_AMUL_LO};
      ST_HMUL_LO: w = '{op: OP_MUL_LO, cnd: CND_NEXT,     use_h: 1'b0, target: ST_LOAD};
      ST_HMUL_HI: w = '{op: OP_MUL_HI, cnd: CND_NEXT,     use_h: 1'b0, target: ST_LOAD};
      ST_HORNER:  w = '{op: OP_HORNER, cnd: CND_K_MORE,   use_h: 1'b0, target: ST_HMUL_LO};
      ST_AMUL_LO: w = '{op: OP_MUL_LO, cnd: CND_NEXT,     use_h: 1'b1, target: ST_LOAD};
      ST_AMUL_HI: w = '{op: OP_MUL_HI, cnd: CND_NEXT,     use_h: 1'b1, target: ST_LOAD};
      ST_SUM:     w = '{op: OP_SUM,    cnd: CND_PT_MORE,  use_h: 1'b0, target: ST_POINT};
      ST_EMIT:    w = '{op: OP_EMIT,   cnd: CND_OUT_BUSY, use_h: 1'b0, target: ST_EMIT};
      ST_WRAP:    w = '{op: OP_NOP,    cnd: CND_ALWAYS,   use_h: 1'b0, target: ST_LOAD};
      default:    w = '{op: OP_NOP,    cnd: CND_ALWAYS,   use_h: 1'b0, target: ST_LOAD};
    endcase
    return w;
  endfunction

  function automatic logic signed [63:0] coef_ext(logic signed [15:0] c);
    return {{40{c[15]}}, c, 8'b0};
  endfunction

endpackage

`default_nettype wire

>>> rtl/pti_cfg_if.sv
`default_nettype none

interface pti_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pti_in_if.sv
`default_nettype none

interface pti_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] lower_limit;
  logic signed [15:0] upper_limit;
  logic [10:0]        interval_count;

  modport source (output valid, output lower_limit, output upper_limit,
                  output interval_count, input ready);
  modport sink   (input valid, input lower_limit, input upper_limit,
                  input interval_count, output ready);
endinterface

`default_nettype wire

>>> rtl/pti_out_if.sv
`default_nettype none

interface pti_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] area;
  logic        bad_count;

  modport source (output valid, output area, output bad_count, input ready);
  modport sink   (input valid, input area, input bad_count, output ready);
endinterface

`default_nettype wire

>>> rtl/polynomial_trapezoid_integrator.sv
// Trapezoid-rule area of a configured polynomial (degree up to 5, 16-bit
// integer coefficients) between two signed Q8.8 limits over N intervals.
// cfg_ch: register writes (0 degree, 1..6 coef_0..coef_5); ready whenever
//   out of reset, write only while no request is in flight.
// in_ch: one transaction per request (lower_limit, upper_limit,
//   interval_count). Taken only while the sequencer waits at its load step.
// out_ch: one transaction per request, area (8 fractional bits, saturating)
//   and bad_count (set, area 0, when interval_count is zero).
// Each request is loaded and checked (N zero goes straight to emit), its step
//   size is divided bit-serially, the Horner steps and the area product and
//   sum run for each of the N+1 points, and the result is emitted; the next
//   request is taken once the program wraps back to its load step. One request
//   is worked on at a time; the shared 32x24 multiplier, two passes per
//   product, is run by the control program once per Horner step and per point.
// N above MAX_INTERVALS is clamped to it, and a degree above 5 to 5.
// The result waits in an output register; the next request is taken while
//   it waits, and the program holds at its emit step until that register
//   frees up when the receiver stalls.
// Reset (synchronous, rst_n low) clears the configuration registers, returns
//   the program to its load step and drops the output valid; no clearing pass.
`default_nettype none

module polynomial_trapezoid_integrator
  import pti_pkg::*;
#(
  parameter int MAX_INTERVALS = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  pti_cfg_if.sink  cfg_ch,
  pti_in_if.sink   in_ch,
  pti_out_if.source out_ch
);

  localparam int N_LIM = (MAX_INTERVALS < 2047) ? MAX_INTERVALS : 2047;
  localparam int CNT_W = $clog2(N_LIM + 1);

  // configuration
  logic [DEG_W-1:0]   deg_r;
  logic signed [15:0] coef_r [NUM_COEF];

  // sequencer
  pc_t   pc_r, pc_nxt;
  ctrl_t ctl;
  logic  cond_hit;

  // datapath
  logic signed [15:0] lo_r;
  logic               h_neg_r;
  logic [CNT_W-1:0]   n_r, i_r;
  logic               bad_r;
  logic [DIV_W-1:0]   dq_r;
  logic [10:0]        rem_r;
  logic [4:0]         dcnt_r;
  logic [23:0]        hm_r;
  logic signed [24:0] x_r;
  logic signed [63:0] acc_r;
  logic [2:0]         k_r;
  logic [86:0]        prod_r;
  logic [62:0]        sum_r;

  logic        out_valid_r;
  logic [62:0] out_area_r;
  logic        out_bad_r;

  logic [DEG_W-1:0]   deg_use;
  logic               in_ready;
  logic               slot_free;
  logic signed [16:0] diff;
  logic [16:0]        diff_neg;
  logic [15:0]        diff_mag;
  logic [CNT_W-1:0]   n_clamp;
  logic [11:0]        div_trial;
  logic [11:0]        div_dsr;
  logic               div_ge;
  logic [11:0]        div_sub;
  logic [24:0]        x_neg;
  logic [23:0]        x_mag;
  logic [63:0]        acc_neg;
  logic [62:0]        acc_mag;
  logic [31:0]        mul_a;
  logic [23:0]        mul_b;
  logic [55:0]        mul_p;
  logic [70:0]        hq;
  logic [62:0]        hm_cap;
  logic               h_sign;
  logic signed [63:0] m_signed;
  logic signed [63:0] acc_new;
  logic               pt_edge;
  logic [70:0]        aq;
  logic [62:0]        term;
  logic [63:0]        sadd;
  logic signed [24:0] h_s;

  assign ctl       = ucode(pc_r);
  assign deg_use   = (deg_r > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_r;
  assign in_ready  = (ctl.op == OP_LOAD) && rst_n;
  assign slot_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready    = in_ready;
  assign cfg_ch.ready   = rst_n;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.area      = out_area_r;
  assign out_ch.bad_count = out_bad_r;

  // step size: |upper - lower| * 256, divided restoring style below
  assign diff     = {in_ch.upper_limit[15], in_ch.upper_limit}
                  - {in_ch.lower_limit[15], in_ch.lower_limit};
  assign diff_neg = -diff;
  assign diff_mag = diff[16] ? diff_neg[15:0] : diff[15:0];
  assign n_clamp  = (in_ch.interval_count > 11'(N_LIM)) ? CNT_W'(N_LIM)
                                                        : CNT_W'(in_ch.interval_count);

  assign div_trial = {rem_r, dq_r[DIV_W-1]};
  assign div_dsr   = 12'(n_r);
  assign div_ge    = (div_trial >= div_dsr);
  assign div_sub   = div_trial - div_dsr;

  assign x_neg   = -x_r;
  assign x_mag   = x_r[24] ? x_neg[23:0] : x_r[23:0];
  assign acc_neg = -acc_r;
  assign acc_mag = acc_r[63] ? acc_neg[62:0] : acc_r[62:0];

  // one 32x24 multiplier, low half of |acc| first, then the high half
  assign mul_a = (ctl.op == OP_MUL_HI) ? {1'b0, acc_mag[62:32]} : acc_mag[31:0];
  assign mul_b = ctl.use_h ? hm_r : x_mag;
  assign mul_p = 56'(mul_a) * 56'(mul_b);

  assign hq       = prod_r[86:16];
  assign hm_cap   = (hq > 71'(HORNER_CAP)) ? HORNER_CAP : hq[62:0];
  assign h_sign   = acc_r[63] ^ x_r[24];
  assign m_signed = h_sign ? -$signed({1'b0, hm_cap}) : $signed({1'b0, hm_cap});
  assign acc_new  = m_signed + coef_ext(coef_r[k_r - 3'd1]);

  // end points carry half weight
  assign pt_edge = (i_r == '0) || (i_r == n_r);
  assign aq      = pt_edge ? {1'b0, prod_r[86:17]} : prod_r[86:16];
  assign term    = (aq > 71'(AREA_MAX)) ? AREA_MAX : aq[62:0];
  assign sadd    = {1'b0, sum_r} + {1'b0, term};
  assign h_s     = h_neg_r ? -$signed({1'b0, hm_r}) : $signed({1'b0, hm_r});

  always_comb begin
    case (ctl.cnd)
      CND_NEXT:     cond_hit = 1'b0;
      CND_ALWAYS:   cond_hit = 1'b1;
      CND_NO_INPUT: cond_hit = !in_ch.valid;
      CND_BAD:      cond_hit = bad_r;
      CND_DIV_BUSY: cond_hit = (dcnt_r != '0);
      CND_DEG_ZERO: cond_hit = (deg_use == '0);
      CND_K_MORE:   cond_hit = (k_r != 3'd1);
      CND_PT_MORE:  cond_hit = (i_r != n_r);
      CND_OUT_BUSY: cond_hit = !slot_free;
      default:      cond_hit = 1'b1;
    endcase
    pc_nxt = cond_hit ? ctl.target : pc_r + pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= '0;
      for (int c = 0; c < NUM_COEF; c++) begin
        coef_r[c] <= '0;
      end
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index) inside
        REG_DEGREE: begin
          deg_r <= cfg_ch.data[DEG_W-1:0];
        end
        [REG_COEF_0:REG_COEF_5]: begin
          coef_r[cfg_ch.index - REG_COEF_0] <= cfg_ch.data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.op == OP_EMIT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        if (in_ch.valid) begin
          lo_r    <= in_ch.lower_limit;
          h_neg_r <= diff[16];
          n_r     <= n_clamp;
          bad_r   <= (in_ch.interval_count == '0);
          dq_r    <= {diff_mag, 8'b0};
          rem_r   <= '0;
          dcnt_r  <= 5'(DIV_W - 1);
          sum_r   <= '0;
        end
      end
      OP_DIV: begin
        rem_r  <= div_ge ? div_sub[10:0] : div_trial[10:0];
        dq_r   <= {dq_r[DIV_W-2:0], div_ge};
        dcnt_r <= dcnt_r - 5'd1;
      end
      OP_SETUP: begin
        hm_r <= dq_r;
        x_r  <= {lo_r[15], lo_r, 8'b0};
        i_r  <= '0;
      end
      OP_HINIT: begin
        acc_r <= coef_ext(coef_r[deg_use]);
        k_r   <= deg_use;
      end
      OP_MUL_LO: begin
        prod_r <= 87'(mul_p);
      end
      OP_MUL_HI: begin
        prod_r <= prod_r + {mul_p[54:0], 32'b0};
      end
      OP_HORNER: begin
        acc_r <= acc_new;
        k_r   <= k_r - 3'd1;
      end
      OP_SUM: begin
        sum_r <= sadd[63] ? AREA_MAX : sadd[62:0];
        i_r   <= i_r + CNT_W'(1);
        x_r   <= x_r + h_s;
      end
      OP_EMIT: begin
        if (slot_free) begin
          out_area_r <= sum_r;
          out_bad_r  <= bad_r;
        end
      end
      default: ;
    endcase
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_area_r == '0))
    else $error("bad_count result with nonzero area");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_DIV) |-> (rem_r < 11'(n_r)))
    else $error("division remainder not below divisor");

  a_pt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r >= ST_POINT && pc_r <= ST_SUM) |-> (i_r <= n_r))
    else $error("point index beyond interval count");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r >= ST_HMUL_LO && pc_r <= ST_HORNER) |-> (k_r != 3'd0 && k_r <= 3'(MAX_DEGREE)))
    else $error("Horner step count out of range");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_EMIT && slot_free) |=> out_valid_r)
    else $error("emitted result not presented");

endmodule

`default_nettype wire

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pti_pkg::*;

  localparam int N_CAP            = 1024;
  localparam int CYCLE_LIMIT      = 10_000_000;
  localparam int TAIL_CYCLES      = 64;
  localparam int RANDOM_PER_PHASE = 26;

  localparam cfg_idx_t    REG_UNUSED = REG_COEF_5 + 3'd1;
  localparam logic [63:0] AREA_SAT   = {1'b0, AREA_MAX};
  localparam logic [63:0] HORNER_SAT = {1'b0, HORNER_CAP};

  typedef struct packed {
    logic [62:0] area;
    logic        bad_count;
  } area_result_t;

  // Holds the register copy and the areas still owed by the block.
  class area_predictor;
    logic [2:0]         degree;
    logic signed [15:0] coef [NUM_COEF];
    area_result_t       pending_areas [$];
    int                 mismatches;
    int                 results_seen;

    function new();
      degree = '0;
      foreach (coef[k]) coef[k] = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // min(floor(a*b / 2^shift), cap) on the full 128-bit product
    function logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int shift,
                                         logic [63:0] cap);
      logic [127:0] wide;
      wide = ({64'd0, a} * {64'd0, b}) >> shift;
      return (wide > {64'd0, cap}) ? cap : wide[63:0];
    endfunction

    // Horner evaluation: x has 16 fractional bits, result 8
    function longint poly_at(longint x);
      int          d;
      longint      acc;
      logic [63:0] m;
      logic [63:0] xm;
      bit          neg;
      d   = (degree > MAX_DEGREE) ? MAX_DEGREE : int'(degree);
      acc = longint'(coef[d]) * 256;
      xm  = magnitude(x);
      while (d > 0) begin
        m   = scaled_product(magnitude(acc), xm, 16, HORNER_SAT);
        neg = (acc < 0) != (x < 0);
        d--;
        acc = neg ? -longint'(m) : longint'(m);
        acc += longint'(coef[d]) * 256;
      end
      return acc;
    endfunction

    function void set_register(cfg_idx_t idx, logic [15:0] value);
      if (idx == REG_DEGREE) begin
        degree = value[2:0];
      end else if (idx >= REG_COEF_0 && idx <= REG_COEF_5) begin
        coef[idx - REG_COEF_0] = value;
      end
      // any other index: drop the write
    endfunction

    function void note_request(logic signed [15:0] lo, logic signed [15:0] up,
                               logic [10:0] n);
      area_result_t want;
      int           steps;
      int           shift;
      longint       h;
      longint       base;
      longint       x;
      logic [63:0]  hm;
      logic [63:0]  sum;
      logic [63:0]  t;
      if (n == 0) begin
        want.area      = '0;
        want.bad_count = 1'b1;
        pending_areas.push_back(want);
        return;
      end
      steps = (n > N_CAP) ? N_CAP : int'(n);
      h     = ((longint'(up) - longint'(lo)) * 256) / longint'(steps);
      hm    = magnitude(h);
      base  = longint'(lo) * 256;
      sum   = '0;
      for (int i = 0; i <= steps; i++) begin
        x     = base + longint'(i) * h;
        // end points carry half weight
        shift = (i == 0 || i == steps) ? 17 : 16;
        t     = scaled_product(hm, magnitude(poly_at(x)), shift, AREA_SAT);
        sum   = (t > AREA_SAT - sum) ? AREA_SAT : sum + t;
      end
      want.area      = sum[62:0];
      want.bad_count = 1'b0;
      pending_areas.push_back(want);
    endfunction

    function void check_area(logic [62:0] area, logic bad_count);
      area_result_t want;
      results_seen++;
      if (pending_areas.size() == 0) begin
        $error("result with nothing expected: area %0d bad_count %0d", area, bad_count);
        mismatches++;
        return;
      end
      want = pending_areas.pop_front();
      if (area !== want.area) begin
        $error("area: expected %0d, got %0d", want.area, area);
        mismatches++;
      end
      if (bad_count !== want.bad_count) begin
        $error("bad_count: expected %0d, got %0d", want.bad_count, bad_count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pti_cfg_if cfg_ch ();
  pti_in_if  in_ch ();
  pti_out_if out_ch ();

  polynomial_trapezoid_integrator #(
    .MAX_INTERVALS(N_CAP)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  area_predictor areas = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int          cycles       = 0;
  int          requests_sent = 0;
  int          config_writes = 0;
  int          directed_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) areas.check_area(out_ch.area, out_ch.bad_count);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, areas.pending_areas.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Hold the sender until the block owes nothing.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (areas.pending_areas.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    areas.set_register(idx, value);
    config_writes++;
  endtask

  task automatic load_config(input logic [15:0] deg, c0, c1, c2, c3, c4, c5,
                             input bit poke_unused);
    drain_results();
    write_register(REG_DEGREE, deg);
    write_register(REG_COEF_0, c0);
    write_register(REG_COEF_0 + 3'd1, c1);
    write_register(REG_COEF_0 + 3'd2, c2);
    write_register(REG_COEF_0 + 3'd3, c3);
    write_register(REG_COEF_0 + 3'd4, c4);
    write_register(REG_COEF_5, c5);
    if (poke_unused) write_register(REG_UNUSED, 16'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_request(input logic [15:0] lo, up, input logic [10:0] n);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.lower_limit    <= lo;
    in_ch.upper_limit    <= up;
    in_ch.interval_count <= n;
    do @(posedge clk); while (!in_ch.ready);
    areas.note_request(lo, up, n);
    requests_sent++;
  endtask

  function automatic logic [15:0] pick_coef();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom);
      default: return 16'(int'($urandom_range(40)) - 20);
    endcase
  endfunction

  // Mostly within +-4.0 so the polynomial stays clear of saturation.
  function automatic logic [15:0] pick_limit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return 16'h7FFF;
    if (r < 8) return 16'h8000;
    if (r < 25) return 16'($urandom);
    return 16'(int'($urandom_range(2048)) - 1024);
  endfunction

  // Keep most counts small; long runs cost a Horner evaluation per point.
  function automatic logic [10:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return 11'd0;
    if (r < 6) return 11'($urandom_range(2047, 1025));
    if (r < 8) return 11'($urandom_range(1024, 129));
    if (r < 25) return 11'($urandom_range(128, 17));
    return 11'($urandom_range(16, 1));
  endfunction

  task automatic run_directed();
    // registers still at reset: zero polynomial
    send_request(16'd0, 16'd256, 11'd1);
    send_request(16'h8000, 16'h7FFF, 11'd2047);
    send_request(16'd100, 16'd200, 11'd0);
    // f(x) = x, with a write to the unused index
    load_config(16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    send_request(-16'sd256, 16'd256, 11'd4);
    send_request(16'd256, -16'sd256, 11'd4);
    send_request(16'd0, 16'd768, 11'd1);
    // x^2 - 3, coef_5 above the degree must be ignored
    load_config(16'd2, -16'sd3, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1000, 1'b0);
    send_request(16'd0, 16'd512, 11'd8);
    send_request(-16'sd512, 16'd512, 11'd16);
    send_request(16'd0, 16'd0, 11'd0);
    // largest coefficients: Horner and area saturation
    load_config(16'd5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_request(16'h8000, 16'h7FFF, 11'd1024);
    send_request(16'h7FFF, 16'h8000, 11'd1);
    send_request(16'h8000, 16'h8000, 11'd1);
    send_request(16'd0, 16'h7FFF, 11'd1025);
    // degree field 7 clamps to 5; most negative coefficients
    load_config(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                1'b1);
    send_request(16'h8000, 16'h7FFF, 11'd3);
    send_request(16'h7FFF, 16'h7FFF, 11'd2047);
    send_request(-16'sd256, 16'd256, 11'd7);
    // cubic with a sign change inside the range
    load_config(16'd3, 16'd5, -16'sd7, 16'd0, 16'd2, 16'h7FFF, 16'h8000, 1'b0);
    send_request(-16'sd1024, 16'd1024, 11'd10);
    send_request(16'd1, 16'd2, 11'd1);
    send_request(-16'sd1, 16'd0, 11'd2);
    directed_count = requests_sent;
  endtask

  task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    int sent;
    int block_len;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent         = 0;
    while (sent < RANDOM_PER_PHASE) begin
      load_config(16'($urandom), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                  pick_coef(), pick_coef(), $urandom_range(3) == 0);
      block_len = $urandom_range(10, 4);
      if (block_len > RANDOM_PER_PHASE - sent) block_len = RANDOM_PER_PHASE - sent;
      repeat (block_len) begin
        send_request(pick_limit(), pick_limit(), pick_count());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    in_ch.valid          = 1'b0;
    in_ch.lower_limit    = '0;
    in_ch.upper_limit    = '0;
    in_ch.interval_count = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random_phase(19, 87);
    run_random_phase(87, 19);
    run_random_phase(0, 0);

    drain_results();
    // catch any stray transaction after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed) over %0d register writes, interval counts",
             requests_sent, directed_count, config_writes);
    $display("zero through clamped, degrees 0..7; checked %0d results, %0d mismatches.",
             areas.results_seen, areas.mismatches);
    if (areas.mismatches == 0 && areas.pending_areas.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
